// ===== hw/rtl/drse_pkg.sv =====
// package for the dark run segment extractor
// types, default sizes, register codes and the row width table
// no dependencies
package drse_pkg;

  localparam int unsigned COL_W   = 7;
  localparam int unsigned ROW_W   = 7;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned ROM_W   = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 7;

  localparam int unsigned MAX_SEGMENTS_DEF = 128;
  localparam int unsigned FRAME_WIDTH_DEF  = 128;
  localparam int unsigned FRAME_ROWS_DEF   = 100;

  localparam logic [COL_W-1:0] GAP_LIMIT_RST = 7'd1;
  localparam logic [COL_W-1:0] EDGE_LOW_RST  = 7'd2;
  localparam logic [COL_W-1:0] EDGE_HIGH_RST = 7'd118;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAP_LIMIT = 2'd0,
    CFG_EDGE_LOW  = 2'd1,
    CFG_EDGE_HIGH = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [COL_W-1:0] gap_limit;
    logic [COL_W-1:0] edge_low;
    logic [COL_W-1:0] edge_high;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] center_x;
    logic [ROW_W-1:0] center_row;
    logic [COL_W-1:0] seg_width;
    logic [6:0]       seg_index;
  } seg_t;

  localparam logic [ROM_W-1:0] WIDTH_ROM [128] = '{
    5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30,
    5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30,
    5'd30, 5'd30, 5'd29, 5'd29, 5'd28, 5'd28, 5'd27, 5'd27, 5'd26, 5'd26,
    5'd25, 5'd25, 5'd25, 5'd25, 5'd25, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24,
    5'd23, 5'd23, 5'd23, 5'd23, 5'd23, 5'd22, 5'd22, 5'd22, 5'd22, 5'd22,
    5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20,
    5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18,
    5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16,
    5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd14, 5'd14, 5'd14, 5'd14, 5'd14,
    5'd13, 5'd13, 5'd13, 5'd13, 5'd13, 5'd12, 5'd12, 5'd12, 5'd12, 5'd12,
    5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0
  };

  function automatic logic [ROM_W-1:0] width_limit(input logic [ROW_W-1:0] row);
    return WIDTH_ROM[row];
  endfunction

endpackage

// ===== hw/rtl/drse_if.sv =====
// valid/ready channel interfaces: pixel input, segment output, register writes
// depends on drse_pkg
interface drse_pix_if;
  import drse_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;
  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface drse_seg_if;
  import drse_pkg::*;
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] center_x;
  logic [ROW_W-1:0] center_row;
  logic [COL_W-1:0] seg_width;
  logic [6:0]       seg_index;
  modport source (output valid, output center_x, output center_row, output seg_width,
                  output seg_index, input ready);
  modport sink   (input valid, input center_x, input center_row, input seg_width,
                  input seg_index, output ready);
endinterface

interface drse_cfg_if;
  import drse_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/drse_cfg_regs.sv =====
// configuration registers: gap limit and edge limits
// depends on drse_pkg and drse_cfg_if
module drse_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  drse_cfg_if.sink          cfg_i,
  output drse_pkg::cfg_t    cfg_o
);
  import drse_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_GAP_LIMIT: cfg_d.gap_limit = cfg_i.data;
        CFG_EDGE_LOW:  cfg_d.edge_low  = cfg_i.data;
        CFG_EDGE_HIGH: cfg_d.edge_high = cfg_i.data;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gap_limit <= GAP_LIMIT_RST;
      cfg_q.edge_low  <= EDGE_LOW_RST;
      cfg_q.edge_high <= EDGE_HIGH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

// ===== hw/rtl/drse_core.sv =====
// per-pixel run tracking: scan position, last dark pixel, run head, segment count
// depends on drse_pkg
module drse_core #(
  parameter int unsigned MAX_SEGMENTS = drse_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned FRAME_WIDTH  = drse_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_ROWS   = drse_pkg::FRAME_ROWS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [drse_pkg::PIX_W-1:0] pixel_i,
  input  logic                       frame_start_i,
  input  drse_pkg::cfg_t             cfg_i,
  output logic                       emit_o,
  output drse_pkg::seg_t             seg_o
);
  import drse_pkg::*;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(FRAME_WIDTH - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(FRAME_ROWS - 1);
  localparam logic [ROW_W-1:0] ROWS     = ROW_W'(FRAME_ROWS);
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_SEGMENTS);

  logic [COL_W-1:0] scan_col_q, scan_col_d;
  logic [ROW_W-1:0] scan_row_q, scan_row_d;
  logic [COL_W-1:0] dark_x_q, dark_x_d;
  logic [ROW_W-1:0] dark_y_q, dark_y_d;
  logic [COL_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [COL_W-1:0] col, last_x, new_x, head, jump, diff;
  logic [ROW_W-1:0] row, last_y, new_y;
  logic [CNT_W-1:0] cnt;
  logic [COL_W:0]   sum;
  logic             close, emit;

  always_comb begin
    col    = frame_start_i ? LAST_COL : scan_col_q;
    row    = frame_start_i ? LAST_ROW : scan_row_q;
    last_x = frame_start_i ? '0 : dark_x_q;
    last_y = frame_start_i ? '0 : dark_y_q;
    head   = frame_start_i ? '0 : head_q;
    cnt    = frame_start_i ? '0 : cnt_q;

    new_x = (pixel_i == '0) ? col : last_x;
    new_y = (pixel_i == '0) ? ROWS - row : last_y;
    jump  = (new_x >= last_x) ? new_x - last_x : last_x - new_x;
    close = (cnt < MAX_CNT)
          && (((jump > cfg_i.gap_limit) && (new_y == last_y)) || (new_y > last_y));
    diff  = head - last_x;
    emit  = close && (head > last_x) && (diff < {2'b00, width_limit(last_y)})
          && (head > cfg_i.edge_low) && (head < cfg_i.edge_high);
    sum   = {1'b0, head} + {1'b0, last_x};
  end

  // next state
  always_comb begin
    scan_col_d = scan_col_q;
    scan_row_d = scan_row_q;
    dark_x_d   = dark_x_q;
    dark_y_d   = dark_y_q;
    head_d     = head_q;
    cnt_d      = cnt_q;
    if (step_i) begin
      if (col == '0) begin
        scan_col_d = LAST_COL;
        scan_row_d = (row == '0) ? LAST_ROW : row - 1'b1;
      end else begin
        scan_col_d = col - 1'b1;
        scan_row_d = row;
      end
      dark_x_d = new_x;
      dark_y_d = new_y;
      head_d   = close ? new_x : head;
      cnt_d    = emit ? cnt + 1'b1 : cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_col_q <= LAST_COL;
      scan_row_q <= LAST_ROW;
      dark_x_q   <= '0;
      dark_y_q   <= '0;
      head_q     <= '0;
      cnt_q      <= '0;
    end else begin
      scan_col_q <= scan_col_d;
      scan_row_q <= scan_row_d;
      dark_x_q   <= dark_x_d;
      dark_y_q   <= dark_y_d;
      head_q     <= head_d;
      cnt_q      <= cnt_d;
    end
  end

  assign emit_o           = emit;
  assign seg_o.center_x   = sum[COL_W:1];
  assign seg_o.center_row = last_y;
  assign seg_o.seg_width  = diff;
  assign seg_o.seg_index  = cnt[6:0];
endmodule

// ===== hw/rtl/dark_run_segment_extractor.sv =====
// top level of the dark run segment extractor
// depends on drse_pkg, drse_if, drse_cfg_regs and drse_core
//
// pix_i takes one pixel item per cycle in reverse raster order, frame_start
// on the first pixel of each frame clears the run state. seg_o gives one
// segment item for each run that closes and passes the edge and width tests.
// cfg_i writes gap_limit, edge_low and edge_high; it is always ready.
// a pixel that is taken sits in the input register and is evaluated against
// the run state when it steps, which loads its segment, if any, into the
// output register that drives seg_o; a waiting segment can hold the step.
// throughput: one pixel per cycle unless an emitting pixel waits.
// when the receiver stalls, a waiting segment holds the output register and
// the input register still drains pixels that emit nothing; a pixel that
// would need the output register waits, and pix_i.ready drops behind it.
// reset clears both valid flags, the run state and loads the cfg defaults.
module dark_run_segment_extractor #(
  parameter int unsigned MAX_SEGMENTS = drse_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned FRAME_WIDTH  = drse_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_ROWS   = drse_pkg::FRAME_ROWS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  drse_pix_if.sink      pix_i,
  drse_seg_if.source    seg_o,
  drse_cfg_if.sink      cfg_i
);
  import drse_pkg::*;

  cfg_t             cfg;
  seg_t             core_seg;
  logic             core_emit;
  logic             s1_valid_q, s1_valid_d;
  logic [PIX_W-1:0] s1_pixel_q;
  logic             s1_start_q;
  logic             out_valid_q, out_valid_d;
  seg_t             out_seg_q;
  logic             step, out_free, pix_take;

  drse_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  drse_core #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_ROWS   (FRAME_ROWS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .pixel_i       (s1_pixel_q),
    .frame_start_i (s1_start_q),
    .cfg_i         (cfg),
    .emit_o        (core_emit),
    .seg_o         (core_seg)
  );

  // a pixel that emits needs the output register free
  assign out_free    = !out_valid_q || seg_o.ready;
  assign step        = s1_valid_q && (out_free || !core_emit);
  assign pix_i.ready = !s1_valid_q || step;
  assign pix_take    = pix_i.valid && pix_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (step) s1_valid_d = 1'b0;
    if (pix_take) s1_valid_d = 1'b1;
    out_valid_d = out_valid_q;
    if (seg_o.ready) out_valid_d = 1'b0;
    if (step && core_emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_take) begin
      s1_pixel_q <= pix_i.pixel;
      s1_start_q <= pix_i.frame_start;
    end
    if (step && core_emit) out_seg_q <= core_seg;
  end

  assign seg_o.valid      = out_valid_q;
  assign seg_o.center_x   = out_seg_q.center_x;
  assign seg_o.center_row = out_seg_q.center_row;
  assign seg_o.seg_width  = out_seg_q.seg_width;
  assign seg_o.seg_index  = out_seg_q.seg_index;

`ifndef SYNTHESIS
  a_width_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_o.valid |-> (seg_o.seg_width != '0) && (seg_o.seg_width < 7'd30))
    else $error("segment width outside the table range");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !seg_o.ready) |=> $stable(out_seg_q))
    else $error("waiting segment overwritten");

  a_stall_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && core_emit && out_valid_q && !seg_o.ready) |-> !pix_i.ready && !step)
    else $error("pixel taken while the output register is blocked");
`endif
endmodule

// ===== dv/tb_dark_run_segment_extractor.sv =====
// testbench for dark_run_segment_extractor: directed pixel table, then random frames
// checked item by item against a behavioural predictor of the run tracker
// depends on drse_pkg, drse_if and the rtl of the block
module tb_dark_run_segment_extractor;
  import drse_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int TIMEOUT_CYCLES = 1_500_000;
  localparam int DRAIN_CYCLES   = 6;
  localparam int MAX_PRINTS     = 100;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             fs;
    logic             typed;
    logic             hit;
    seg_t             seg;
  } dir_row_t;

  localparam seg_t SEG_NONE = '0;

  // default registers: gap 1, edges 2 and 118
  localparam dir_row_t DIR_TAB [0:20] = '{
    '{8'hFF, 1'b1, 1'b1, 1'b0, SEG_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, SEG_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, SEG_NONE},
    '{8'h01, 1'b0, 1'b0, 1'b0, SEG_NONE},
    '{8'h02, 1'b0, 1'b0, 1'b0, SEG_NONE},
    '{8'h04, 1'b0, 1'b0, 1'b0, SEG_NONE},
    '{8'h08, 1'b0, 1'b0, 1'b0, SEG_NONE},
    '{8'h10, 1'b0, 1'b0, 1'b0, SEG_NONE},
    '{8'h20, 1'b0, 1'b0, 1'b0, SEG_NONE},
    '{8'h40, 1'b0, 1'b0, 1'b0, SEG_NONE},
    '{8'h80, 1'b0, 1'b0, 1'b0, SEG_NONE},
    // run head beyond the right edge limit
    '{8'h00, 1'b0, 1'b1, 1'b0, SEG_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, SEG_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, SEG_NONE},
    '{8'hAA, 1'b0, 1'b0, 1'b0, SEG_NONE},
    '{8'h00, 1'b0, 1'b1, 1'b1, '{7'd115, 7'd1, 7'd2, 7'd0}},
    '{8'h00, 1'b0, 1'b0, 1'b0, SEG_NONE},
    '{8'h55, 1'b0, 1'b0, 1'b0, SEG_NONE},
    // frame restart drops the open run
    '{8'h00, 1'b1, 1'b1, 1'b0, SEG_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, SEG_NONE},
    '{8'hFF, 1'b0, 1'b0, 1'b0, SEG_NONE}
  };

  logic clk_i;
  logic rst_ni;

  drse_pix_if pix_ch ();
  drse_seg_if seg_ch ();
  drse_cfg_if cfg_ch ();

  dark_run_segment_extractor uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix_ch),
    .seg_o (seg_ch),
    .cfg_i (cfg_ch)
  );

  // predictor state
  int unsigned      pos_col;
  int unsigned      pos_row;
  logic [COL_W-1:0] mark_x;
  logic [ROW_W-1:0] mark_y;
  logic [COL_W-1:0] run_head;
  logic [CNT_W-1:0] emitted;
  logic [COL_W-1:0] gap_lim;
  logic [COL_W-1:0] edge_lo;
  logic [COL_W-1:0] edge_hi;

  seg_t pending_segs [$];
  seg_t seg_want;
  int   fail_cnt;
  int   segs_seen;
  int   src_idle;
  int   snk_stall;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("FAILURE");
    $finish;
  end

  function automatic void clear_frame();
    pos_col  = FRAME_WIDTH_DEF - 1;
    pos_row  = FRAME_ROWS_DEF - 1;
    mark_x   = '0;
    mark_y   = '0;
    run_head = '0;
    emitted  = '0;
  endfunction

  function automatic bit track_pixel(input logic [PIX_W-1:0] pix, input logic fs,
                                     output seg_t seg);
    logic [COL_W-1:0] prev_x;
    logic [COL_W-1:0] next_x;
    logic [COL_W-1:0] col_jump;
    logic [ROW_W-1:0] prev_y;
    logic [ROW_W-1:0] next_y;
    bit               hit;
    hit = 1'b0;
    seg = SEG_NONE;
    if (fs) clear_frame();
    prev_x = mark_x;
    prev_y = mark_y;
    next_x = prev_x;
    next_y = prev_y;
    if (pix == '0) begin
      next_x = COL_W'(pos_col);
      next_y = ROW_W'(FRAME_ROWS_DEF - pos_row);
    end
    if (emitted < MAX_SEGMENTS_DEF) begin
      col_jump = (next_x >= prev_x) ? next_x - prev_x : prev_x - next_x;
      if ((col_jump > gap_lim && next_y == prev_y) || next_y > prev_y) begin
        if (run_head > prev_x && (run_head - prev_x) < WIDTH_ROM[prev_y] &&
            run_head > edge_lo && run_head < edge_hi) begin
          seg.center_x   = COL_W'((int'(run_head) + int'(prev_x)) >> 1);
          seg.center_row = prev_y;
          seg.seg_width  = run_head - prev_x;
          seg.seg_index  = emitted[6:0];
          emitted        = emitted + 1'b1;
          hit            = 1'b1;
        end
        run_head = next_x;
      end
    end
    mark_x = next_x;
    mark_y = next_y;
    if (pos_col == 0) begin
      pos_col = FRAME_WIDTH_DEF - 1;
      pos_row = (pos_row == 0) ? FRAME_ROWS_DEF - 1 : pos_row - 1;
    end else begin
      pos_col = pos_col - 1;
    end
    return hit;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_cnt < MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
    fail_cnt++;
  endtask

  task automatic check_field(input string name, input logic [6:0] got, input logic [6:0] want);
    if (got !== want)
      report_mismatch($sformatf("segment %0d %s got %0d want %0d", segs_seen, name, got, want));
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs,
                            input logic typed, input logic typed_hit, input seg_t typed_seg);
    seg_t seg;
    bit   hit;
    while ($urandom_range(99) < src_idle) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel       <= pix;
    pix_ch.frame_start <= fs;
    @(posedge clk_i);
    while (!pix_ch.ready) @(posedge clk_i);
    hit = track_pixel(pix, fs, seg);
    if (typed) begin
      hit = typed_hit;
      seg = typed_seg;
    end
    if (hit) pending_segs.push_back(seg);
  endtask

  // sender holds off until every segment is out and the pipe has emptied
  task automatic settle();
    pix_ch.valid <= 1'b0;
    while (pending_segs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DAT_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (idx)
      CFG_GAP_LIMIT: gap_lim = val;
      CFG_EDGE_LOW:  edge_lo = val;
      CFG_EDGE_HIGH: edge_hi = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [6:0] gap, input logic [6:0] lo, input logic [6:0] hi);
    write_reg(CFG_GAP_LIMIT, gap);
    write_reg(CFG_EDGE_LOW, lo);
    write_reg(CFG_EDGE_HIGH, hi);
    cfg_ch.valid <= 1'b0;
  endtask

  // frames of dark runs and light gaps, with some noise pixels and stray restarts
  task automatic feed_frames(input int n_items, input int len_lo, input int len_hi,
                             input int gap_max, input bit stray_starts);
    int               left_in_frame;
    int               dark_left;
    int               light_left;
    logic [PIX_W-1:0] pix;
    logic             fs;
    left_in_frame = 0;
    dark_left     = 0;
    light_left    = 0;
    for (int k = 0; k < n_items; k++) begin
      fs = 1'b0;
      if (left_in_frame == 0 || (stray_starts && $urandom_range(299) == 0)) begin
        fs            = 1'b1;
        left_in_frame = $urandom_range(len_hi, len_lo);
      end
      left_in_frame--;
      if (dark_left == 0 && light_left == 0) begin
        dark_left  = $urandom_range(4, 1);
        light_left = $urandom_range(gap_max, 0);
      end
      if ($urandom_range(99) < 8) begin
        pix = PIX_W'($urandom);
      end else if (dark_left != 0) begin
        pix = '0;
        dark_left--;
      end else begin
        pix = PIX_W'($urandom_range(255, 1));
        light_left--;
      end
      send_pixel(pix, fs, 1'b0, 1'b0, SEG_NONE);
      if (stray_starts && $urandom_range(499) == 0) settle();
    end
  endtask

  always @(posedge clk_i) seg_ch.ready <= ($urandom_range(99) >= snk_stall);

  always @(posedge clk_i) begin
    if (rst_ni && seg_ch.valid && seg_ch.ready) begin
      if (pending_segs.size() == 0) begin
        report_mismatch($sformatf("segment %0d with none expected: x %0d row %0d w %0d idx %0d",
                                  segs_seen, seg_ch.center_x, seg_ch.center_row,
                                  seg_ch.seg_width, seg_ch.seg_index));
      end else begin
        seg_want = pending_segs.pop_front();
        check_field("center_x", seg_ch.center_x, seg_want.center_x);
        check_field("center_row", seg_ch.center_row, seg_want.center_row);
        check_field("seg_width", seg_ch.seg_width, seg_want.seg_width);
        check_field("seg_index", seg_ch.seg_index, seg_want.seg_index);
      end
      segs_seen++;
    end
  end

  initial begin
    pix_ch.valid       = 1'b0;
    pix_ch.pixel       = '0;
    pix_ch.frame_start = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_GAP_LIMIT;
    cfg_ch.data        = '0;
    seg_ch.ready       = 1'b0;
    rst_ni             = 1'b0;
    fail_cnt           = 0;
    segs_seen          = 0;
    src_idle           = 0;
    snk_stall          = 0;
    gap_lim            = GAP_LIMIT_RST;
    edge_lo            = EDGE_LOW_RST;
    edge_hi            = EDGE_HIGH_RST;
    clear_frame();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_TAB[k])
      send_pixel(DIR_TAB[k].pixel, DIR_TAB[k].fs, DIR_TAB[k].typed, DIR_TAB[k].hit,
                 DIR_TAB[k].seg);
    settle();

    // dense frame that runs into the segment limit
    set_config(7'd1, 7'd0, 7'd127);
    snk_stall = 65;
    for (int k = 0; k < 450; k++)
      send_pixel((k % 3 == 2) ? PIX_W'($urandom_range(255, 1)) : '0, k == 0, 1'b0, 1'b0,
                 SEG_NONE);
    settle();

    set_config(7'd0, 7'd0, 7'd127);
    src_idle  = 0;
    snk_stall = 0;
    feed_frames(100, 100, 400, 4, 1'b1);
    settle();

    set_config(7'($urandom_range(6, 1)), 7'($urandom_range(20)), 7'($urandom_range(127, 100)));
    src_idle  = 65;
    snk_stall = 0;
    feed_frames(120, 100, 400, 8, 1'b1);
    settle();

    set_config(7'd127, 7'd0, 7'd127);
    src_idle  = 0;
    snk_stall = 65;
    feed_frames(100, 130, 400, 6, 1'b1);
    settle();

    set_config(7'($urandom_range(127)), 7'($urandom_range(127)), 7'($urandom_range(127)));
    src_idle  = 25;
    snk_stall = 25;
    feed_frames(100, 100, 400, 6, 1'b1);
    settle();

    set_config(7'd127, 7'd127, 7'd0);
    feed_frames(40, 20, 60, 4, 1'b1);
    settle();

    if (fail_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== dark_run_segment_extractor.f =====
hw/rtl/drse_pkg.sv
hw/rtl/drse_if.sv
hw/rtl/drse_cfg_regs.sv
hw/rtl/drse_core.sv
hw/rtl/dark_run_segment_extractor.sv
dv/tb_dark_run_segment_extractor.sv
